>>> design/uepf_pkg.sv
package uepf_pkg;

    localparam int TAIL_DEPTH  = 4;
    localparam int GLYPH_DEPTH = 4;
    localparam int CP_W        = 21;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EMOJI_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STYLE    = 1'd1;

    localparam logic [1:0] STYLE_AUTO   = 2'd0;
    localparam logic [1:0] STYLE_COLOR  = 2'd1;
    localparam logic [1:0] STYLE_UNUSED = 2'd3;

    // selector byte forms: EF B8 8E/8F, overlong F0 8F B8 8E/8F
    localparam logic [7:0] VS_LEAD3 = 8'hEF;
    localparam logic [7:0] VS_LEAD4 = 8'hF0;
    localparam logic [7:0] VS_OVL   = 8'h8F;
    localparam logic [7:0] VS_MID   = 8'hB8;
    localparam logic [7:0] VS_TEXT  = 8'h8E;
    localparam logic [7:0] VS_COLOR = 8'h8F;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data;
        logic       is_cont;
        logic [2:0] seq_len;
    } t_byte_cls;

    typedef t_byte_cls [TAIL_DEPTH-1:0] t_tail;

    typedef struct packed {
        t_byte_cls cls;
        logic      last;
    } t_q_item;

    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_q_head;

    typedef struct packed {
        logic      push;
        t_out_item item;
    } t_res_push;

    typedef struct packed {
        logic       emoji_en;
        logic [1:0] style;
    } t_cfg;

    function automatic t_byte_cls classify(input logic [7:0] b);
        t_byte_cls c;
        c.data    = b;
        c.is_cont = (b & CONT_MASK) == CONT_TAG;
        if (!b[7]) begin
            c.seq_len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            c.seq_len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            c.seq_len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            c.seq_len = 3'd4;
        end else begin
            c.seq_len = 3'd1;
        end
        return c;
    endfunction

    function automatic logic eligible(input logic [CP_W-1:0] cp);
        return (cp >= 21'h02190 && cp <= 21'h021FF) || (cp >= 21'h02300 && cp <= 21'h023FF)
            || (cp >= 21'h025A0 && cp <= 21'h025FF) || (cp >= 21'h02600 && cp <= 21'h027BF)
            || (cp >= 21'h02B00 && cp <= 21'h02BFF) || (cp >= 21'h1F000 && cp <= 21'h1FFFF);
    endfunction

endpackage

>>> design/uepf_front.sv
module uepf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  uepf_pkg::t_in_item  i_in_data,
    output uepf_pkg::t_q_head   o_q,
    input  logic                i_q_pop
);
    import uepf_pkg::*;

    t_q_item    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && (r_cnt != 2'd0);

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{cls: classify(i_in_data.in_byte), last: i_in_data.string_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

>>> design/uepf_back.sv
module uepf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  uepf_pkg::t_cfg      i_cfg,
    input  uepf_pkg::t_q_head   i_q,
    output logic                o_q_pop,
    input  logic                i_res_full,
    output uepf_pkg::t_res_push o_res
);
    import uepf_pkg::*;

    typedef enum logic [1:0] {MATCH_NO, MATCH_FULL, MATCH_PART} t_match;

    localparam logic [1:0] SFX_LEN = 2'd3;

    t_tail                        r_tail, n_tail;
    logic [2:0]                   r_tail_cnt, n_tail_cnt;
    logic [GLYPH_DEPTH-1:0][7:0]  r_glyph, n_glyph;
    logic [2:0]                   r_glyph_cnt, n_glyph_cnt;
    logic                         r_held, n_held;
    logic [2:0]                   r_emit_cnt, n_emit_cnt;
    logic [1:0]                   r_sfx_cnt, n_sfx_cnt;
    logic                         r_busy, n_busy;
    logic                         r_final, n_final;
    logic                         r_marker_done, n_marker_done;
    t_out_item                    r_stg, n_stg;
    logic                         r_stg_vld, n_stg_vld;

    logic            w_pt;
    logic [2:0]      w_append_cnt;
    logic            w_new_vld;
    t_out_item       w_new_res;
    logic            w_load;

    logic [3:0]      w_hit3, w_hit4;
    t_match          w_m3, w_m4;
    logic            w_sel_wait;
    logic [2:0]      w_sel_len;

    logic            w_dec_wait;
    logic [2:0]      w_dec_len;
    logic            w_dec_done;
    logic [CP_W-1:0] w_cp;
    logic            w_dec_elig;

    function automatic t_tail shift_tail(input t_tail t, input logic [2:0] s);
        return t_tail'(t >> (32'(s) * $bits(t_byte_cls)));
    endfunction

    function automatic t_match match_form(input logic [3:0] hit, input logic [2:0] len,
                                          input logic [2:0] cnt);
        t_match m;
        logic   fin;
        m   = MATCH_FULL;
        fin = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (!fin && 3'(k) < len) begin
                if (3'(k) >= cnt) begin
                    m   = MATCH_PART;
                    fin = 1'b1;
                end else if (!hit[k]) begin
                    m   = MATCH_NO;
                    fin = 1'b1;
                end
            end
        end
        return m;
    endfunction

    function automatic logic vs_end(input logic [7:0] b);
        return (b == VS_TEXT) || (b == VS_COLOR);
    endfunction

    function automatic t_out_item byte_res(input logic [7:0] b);
        return '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, string_end: 1'b0};
    endfunction

    // selector check on the bytes after a held glyph
    always_comb begin
        w_hit3 = {1'b0, vs_end(r_tail[2].data), r_tail[1].data == VS_MID,
                  r_tail[0].data == VS_LEAD3};
        w_hit4 = {vs_end(r_tail[3].data), r_tail[2].data == VS_MID,
                  r_tail[1].data == VS_OVL, r_tail[0].data == VS_LEAD4};
        w_m3 = match_form(w_hit3, 3'd3, r_tail_cnt);
        w_m4 = match_form(w_hit4, 3'd4, r_tail_cnt);
        w_sel_wait = 1'b0;
        w_sel_len  = 3'd0;
        if (w_m3 == MATCH_FULL) begin
            w_sel_len = 3'd3;
        end else if (w_m4 == MATCH_FULL) begin
            w_sel_len = 3'd4;
        end else if ((w_m3 == MATCH_PART || w_m4 == MATCH_PART) && !r_final) begin
            w_sel_wait = 1'b1;
        end
    end

    // lenient decode at the front of the tail
    always_comb begin
        w_dec_len  = r_tail[0].seq_len;
        w_dec_wait = 1'b0;
        w_dec_done = 1'b0;
        for (int k = 1; k < 4; k++) begin
            if (!w_dec_done && 3'(k) < r_tail[0].seq_len) begin
                if (3'(k) >= r_tail_cnt) begin
                    w_dec_done = 1'b1;
                    w_dec_len  = 3'd1;
                    w_dec_wait = !r_final;
                end else if (!r_tail[k].is_cont) begin
                    w_dec_done = 1'b1;
                    w_dec_len  = 3'd1;
                end
            end
        end
        case (r_tail[0].seq_len)
            3'd2: w_cp = CP_W'({r_tail[0].data[4:0], r_tail[1].data[5:0]});
            3'd3: w_cp = CP_W'({r_tail[0].data[3:0], r_tail[1].data[5:0],
                                r_tail[2].data[5:0]});
            3'd4: w_cp = {r_tail[0].data[2:0], r_tail[1].data[5:0], r_tail[2].data[5:0],
                          r_tail[3].data[5:0]};
            default: w_cp = CP_W'(r_tail[0].data);
        endcase
        w_dec_elig = !w_dec_wait && (w_dec_len == r_tail[0].seq_len)
                  && (r_tail[0].seq_len != 3'd1) && eligible(w_cp);
    end

    always_comb begin
        n_tail        = r_tail;
        n_tail_cnt    = r_tail_cnt;
        n_glyph       = r_glyph;
        n_glyph_cnt   = r_glyph_cnt;
        n_held        = r_held;
        n_emit_cnt    = r_emit_cnt;
        n_sfx_cnt     = r_sfx_cnt;
        n_busy        = r_busy;
        n_final       = r_final;
        n_marker_done = r_marker_done;
        n_stg         = r_stg;
        n_stg_vld     = r_stg_vld;
        w_new_vld     = 1'b0;
        w_new_res     = '0;
        w_load        = 1'b0;
        o_res         = '0;
        o_q_pop       = 1'b0;
        w_pt          = i_cfg.emoji_en
                     && (i_cfg.style == STYLE_AUTO || i_cfg.style == STYLE_UNUSED);
        w_append_cnt  = r_tail_cnt[2] ? r_tail_cnt : r_tail_cnt + 3'd1;

        if (r_busy) begin
            if (!i_res_full) begin
                if (!r_held && r_glyph_cnt != 3'd0) begin
                    w_new_vld   = 1'b1;
                    w_new_res   = byte_res(r_glyph[0]);
                    n_glyph     = r_glyph >> 8;
                    n_glyph_cnt = r_glyph_cnt - 3'd1;
                end else if (r_sfx_cnt != 2'd0) begin
                    w_new_vld = 1'b1;
                    case (r_sfx_cnt)
                        2'd3:    w_new_res = byte_res(VS_LEAD3);
                        2'd2:    w_new_res = byte_res(VS_MID);
                        default: w_new_res = byte_res((i_cfg.style == STYLE_COLOR) ?
                                                      VS_COLOR : VS_TEXT);
                    endcase
                    n_sfx_cnt = r_sfx_cnt - 2'd1;
                end else if (r_emit_cnt != 3'd0) begin
                    w_new_vld  = 1'b1;
                    w_new_res  = byte_res(r_tail[0].data);
                    n_tail     = shift_tail(r_tail, 3'd1);
                    n_tail_cnt = r_tail_cnt - 3'd1;
                    n_emit_cnt = r_emit_cnt - 3'd1;
                end else if (r_held && !w_sel_wait) begin
                    n_tail     = shift_tail(r_tail, w_sel_len);
                    n_tail_cnt = r_tail_cnt - w_sel_len;
                    n_held     = 1'b0;
                    if (i_cfg.emoji_en) begin
                        n_sfx_cnt = SFX_LEN;
                    end else begin
                        n_glyph_cnt = 3'd0;
                    end
                end else if (!r_held && r_tail_cnt != 3'd0 && !w_dec_wait) begin
                    if (w_dec_elig) begin
                        for (int i = 0; i < GLYPH_DEPTH; i++) begin
                            n_glyph[i] = r_tail[i].data;
                        end
                        n_glyph_cnt = w_dec_len;
                        n_held      = 1'b1;
                        n_tail      = shift_tail(r_tail, w_dec_len);
                        n_tail_cnt  = r_tail_cnt - w_dec_len;
                    end else begin
                        w_new_vld  = 1'b1;
                        w_new_res  = byte_res(r_tail[0].data);
                        n_tail     = shift_tail(r_tail, 3'd1);
                        n_tail_cnt = r_tail_cnt - 3'd1;
                        n_emit_cnt = w_dec_len - 3'd1;
                    end
                end else if (r_final && !r_marker_done) begin
                    w_new_vld     = 1'b1;
                    w_new_res     = '{out_byte: 8'd0, byte_valid: 1'b0, run_last: 1'b0,
                                      string_end: 1'b1};
                    n_marker_done = 1'b1;
                    n_held        = 1'b0;
                    n_tail_cnt    = 3'd0;
                    n_glyph_cnt   = 3'd0;
                end else begin
                    // run over: release the held-back result as the last one
                    if (r_stg_vld) begin
                        o_res.push          = 1'b1;
                        o_res.item          = r_stg;
                        o_res.item.run_last = 1'b1;
                    end
                    n_stg_vld = 1'b0;
                    n_busy    = 1'b0;
                    w_load    = i_q.valid;
                end

                if (w_new_vld) begin
                    if (r_stg_vld) begin
                        o_res.push = 1'b1;
                        o_res.item = r_stg;
                    end
                    n_stg     = w_new_res;
                    n_stg_vld = 1'b1;
                end
            end
        end else begin
            w_load = i_q.valid;
        end

        if (w_load) begin
            o_q_pop = 1'b1;
            n_busy  = 1'b1;
            if (!r_tail_cnt[2]) begin
                n_tail[r_tail_cnt[1:0]] = i_q.item.cls;
            end
            n_tail_cnt    = w_append_cnt;
            n_final       = i_q.item.last;
            n_marker_done = 1'b0;
            if (w_pt) begin
                n_emit_cnt = w_append_cnt;
                n_held     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail  <= n_tail;
        r_glyph <= n_glyph;
        r_stg   <= n_stg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_cnt    <= 3'd0;
            r_glyph_cnt   <= 3'd0;
            r_held        <= 1'b0;
            r_emit_cnt    <= 3'd0;
            r_sfx_cnt     <= 2'd0;
            r_busy        <= 1'b0;
            r_final       <= 1'b0;
            r_marker_done <= 1'b0;
            r_stg_vld     <= 1'b0;
        end else begin
            r_tail_cnt    <= n_tail_cnt;
            r_glyph_cnt   <= n_glyph_cnt;
            r_held        <= n_held;
            r_emit_cnt    <= n_emit_cnt;
            r_sfx_cnt     <= n_sfx_cnt;
            r_busy        <= n_busy;
            r_final       <= n_final;
            r_marker_done <= n_marker_done;
            r_stg_vld     <= n_stg_vld;
        end
    end

endmodule

>>> design/uepf_obuf.sv
module uepf_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  uepf_pkg::t_res_push i_res,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output uepf_pkg::t_out_item o_out_data
);
    import uepf_pkg::*;

    t_out_item  r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_full      = (r_cnt == 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_mem[r_rp];
    assign w_pop       = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_res.push) begin
            r_mem[r_wp] <= i_res.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_res.push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_res.push} - {1'b0, w_pop};
        end
    end

endmodule

>>> design/utf8_emoji_presentation_filter_top.sv
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_ready    i_in_data: in_byte, string_last
// out      out  o_out_valid / i_out_ready  o_out_data: out_byte, byte_valid, run_last, string_end
// cfg      in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// In the back-end sequencer a plain ASCII byte needs one decision that emits it and
// one that closes the run and loads the next byte. Every further output byte adds a
// decision (one result per cycle out of the sequencer while the output buffer is not
// full), as do a glyph hand-off, a selector decision and the string-end marker.
// Synchronous active-low reset; no clearing pass. Two-entry queues on both sides
// let input and output stall independently.
module utf8_emoji_presentation_filter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  uepf_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output uepf_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [uepf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [uepf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import uepf_pkg::*;

    logic       r_emoji_en;
    logic [1:0] r_style;
    t_cfg       w_cfg;
    t_q_head    w_q;
    logic       w_q_pop;
    t_res_push  w_res;
    logic       w_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emoji_en <= 1'b1;
            r_style    <= STYLE_AUTO;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EMOJI_EN: r_emoji_en <= i_cfg_data[0];
                CFG_STYLE:    r_style    <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg = '{emoji_en: r_emoji_en, style: r_style};

    uepf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q        (w_q),
        .i_q_pop    (w_q_pop)
    );

    uepf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q        (w_q),
        .o_q_pop    (w_q_pop),
        .i_res_full (w_res_full),
        .o_res      (w_res)
    );

    uepf_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (w_res),
        .o_full      (w_res_full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
